// File: rtl/nnc_pkg.sv
`default_nettype none
package nnc_pkg;

	// Field widths
	localparam int AXIS_W   = 18;
	localparam int LABEL_W  = 3;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;

	// Distance datapath widths: difference, square, sum of three squares
	localparam int DIFF_W = AXIS_W + 1;
	localparam int SQ_W   = 2 * AXIS_W + 1;
	localparam int DIST_W = SQ_W + 2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOISE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

	// Unit bounds in Q2.15
	localparam logic signed [AXIS_W-1:0] Q_ONE     = 18'sd32768;
	localparam logic signed [AXIS_W-1:0] Q_NEG_ONE = -18'sd32768;

	// One stored training point
	typedef struct packed {
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] z;
		logic [LABEL_W-1:0]       label;
	} point_t;

	// Sideband that travels with each distance through the pipe
	typedef struct packed {
		logic               vld;
		logic               ok;
		logic               first;
		logic               last;
		logic [LABEL_W-1:0] label;
	} tag_t;

endpackage
`default_nettype wire

// File: rtl/nnc_req_if.sv
`default_nettype none
interface nnc_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [nnc_pkg::CMD_W-1:0]             cmd;
	logic signed [nnc_pkg::AXIS_W-1:0]     point_x;
	logic signed [nnc_pkg::AXIS_W-1:0]     point_y;
	logic signed [nnc_pkg::AXIS_W-1:0]     point_z;
	logic [nnc_pkg::LABEL_W-1:0]           class_label;

	modport source (output valid, cmd, point_x, point_y, point_z, class_label, input ready);
	modport sink (input valid, cmd, point_x, point_y, point_z, class_label, output ready);
endinterface
`default_nettype wire

// File: rtl/nnc_rsp_if.sv
`default_nettype none
interface nnc_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [nnc_pkg::LABEL_W-1:0]    predicted_label;
	logic [nnc_pkg::STATUS_W-1:0]   status;

	modport source (output valid, predicted_label, status, input ready);
	modport sink (input valid, predicted_label, status, output ready);
endinterface
`default_nettype wire

// File: rtl/nnc_cell.sv
`default_nettype none
module nnc_cell (
	input  wire logic            clk,
	input  wire logic            wr,
	input  wire nnc_pkg::point_t wr_data,
	input  wire logic            shift,
	input  wire nnc_pkg::point_t nbr,
	output nnc_pkg::point_t      pt
);

	nnc_pkg::point_t pt_q;

	// Take a new training point, or pass the ring along by one place
	always_ff @(posedge clk) begin
		if (wr) begin
			pt_q <= wr_data;
		end else if (shift) begin
			pt_q <= nbr;
		end
	end

	assign pt = pt_q;

endmodule
`default_nettype wire

// File: rtl/nnc_dist.sv
`default_nettype none
module nnc_dist (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire nnc_pkg::point_t                   pt,
	input  wire logic signed [nnc_pkg::AXIS_W-1:0] qx,
	input  wire logic signed [nnc_pkg::AXIS_W-1:0] qy,
	input  wire logic signed [nnc_pkg::AXIS_W-1:0] qz,
	input  wire nnc_pkg::tag_t                     tag_in,
	output logic [nnc_pkg::DIST_W-1:0]             dist_sq,
	output nnc_pkg::tag_t                          tag_out
);

	localparam int DW = nnc_pkg::DIFF_W;
	localparam int SW = nnc_pkg::SQ_W;

	logic signed [DW-1:0]   dx_s1, dy_s1, dz_s1;
	logic signed [2*DW-1:0] px, py, pz;
	logic [SW-1:0]          sqx_s2, sqy_s2, sqz_s2;
	logic [nnc_pkg::DIST_W-1:0] dist_s3;
	nnc_pkg::tag_t          tag_s1, tag_s2, tag_s3;

	// Square each difference
	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;
	assign pz = dz_s1 * dz_s1;

	// Stage payload: difference, square, sum
	always_ff @(posedge clk) begin
		dx_s1   <= {pt.x[nnc_pkg::AXIS_W-1], pt.x} - {qx[nnc_pkg::AXIS_W-1], qx};
		dy_s1   <= {pt.y[nnc_pkg::AXIS_W-1], pt.y} - {qy[nnc_pkg::AXIS_W-1], qy};
		dz_s1   <= {pt.z[nnc_pkg::AXIS_W-1], pt.z} - {qz[nnc_pkg::AXIS_W-1], qz};
		sqx_s2  <= px[SW-1:0];
		sqy_s2  <= py[SW-1:0];
		sqz_s2  <= pz[SW-1:0];
		dist_s3 <= {2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2};
	end

	// Advance the sideband alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	assign dist_sq = dist_s3;
	assign tag_out = tag_s3;

endmodule
`default_nettype wire

// File: rtl/nearest_neighbour_classifier.sv
`default_nettype none
// Load, clear, unused commands and rejected queries: result in the cycle after the request.
// Classify query with stored points: result once the last point leaves the distance unit;
// the point ring rotates once past a single three-stage distance unit, one point a cycle.
// A new request is taken only while no scan runs and the result register can accept.
// Reset clears the point count, scan state and result register; point cells keep
// whatever they hold; only those below the count can win a scan.
module nearest_neighbour_classifier #(
	parameter int MaxPoints = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nnc_req_if.sink    req,
	nnc_rsp_if.source  rsp
);

	localparam int IW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
	localparam int CW = $clog2(MaxPoints + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] k_q;

	logic signed [nnc_pkg::AXIS_W-1:0] qx_q, qy_q, qz_q;
	logic [nnc_pkg::DIST_W-1:0]        best_dist_q;
	logic [nnc_pkg::LABEL_W-1:0]       best_label_q;

	logic                              out_valid_q;
	logic [nnc_pkg::LABEL_W-1:0]       out_label_q;
	logic [nnc_pkg::STATUS_W-1:0]      out_status_q;

	logic            fire, has_room, noisy, do_load, issuing, last_issue;
	nnc_pkg::point_t new_pt;
	nnc_pkg::point_t cell_pt [MaxPoints];
	nnc_pkg::tag_t   tag_in, tag_out;
	logic [nnc_pkg::DIST_W-1:0] dist_sq;
	logic            take_best;

	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign fire      = req.valid && req.ready;
	assign has_room  = count_q < CW'(MaxPoints);
	assign noisy     = (req.point_x < nnc_pkg::Q_NEG_ONE) || (req.point_x > nnc_pkg::Q_ONE) ||
	                   (req.point_y < nnc_pkg::Q_NEG_ONE) || (req.point_y > nnc_pkg::Q_ONE) ||
	                   (req.point_z < nnc_pkg::Q_NEG_ONE) || (req.point_z > nnc_pkg::Q_ONE);
	assign do_load   = fire && (req.cmd == nnc_pkg::CMD_LOAD) && has_room;
	assign issuing   = (state_q == S_ISSUE);
	assign last_issue = (k_q == IW'(MaxPoints - 1));

	assign new_pt.x     = req.point_x;
	assign new_pt.y     = req.point_y;
	assign new_pt.z     = req.point_z;
	assign new_pt.label = req.class_label;

	// Ring of point cells; the head feeds the distance unit
	for (genvar i = 0; i < MaxPoints; i++) begin : g_cell
		nnc_pkg::point_t nbr;
		if (i == MaxPoints - 1) begin : g_wrap
			assign nbr = cell_pt[0];
		end else begin : g_next
			assign nbr = cell_pt[i + 1];
		end
		nnc_cell u_cell (
			.clk     (clk),
			.wr      (do_load && (count_q[IW-1:0] == IW'(i))),
			.wr_data (new_pt),
			.shift   (issuing),
			.nbr     (nbr),
			.pt      (cell_pt[i])
		);
	end

	// Tag each head point with its place in the scan
	assign tag_in.vld   = issuing;
	assign tag_in.ok    = issuing && (CW'(k_q) < count_q);
	assign tag_in.first = (k_q == '0);
	assign tag_in.last  = last_issue;
	assign tag_in.label = cell_pt[0].label;

	nnc_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.pt      (cell_pt[0]),
		.qx      (qx_q),
		.qy      (qy_q),
		.qz      (qz_q),
		.tag_in  (tag_in),
		.dist_sq (dist_sq),
		.tag_out (tag_out)
	);

	// Keep the earliest strictly nearest point
	assign take_best = tag_out.vld && tag_out.ok && (tag_out.first || (dist_sq < best_dist_q));

	always_ff @(posedge clk) begin
		if (take_best) begin
			best_dist_q  <= dist_sq;
			best_label_q <= tag_out.label;
		end
		if (fire) begin
			qx_q <= req.point_x;
			qy_q <= req.point_y;
			qz_q <= req.point_z;
		end
	end

	// Sequence requests and scans, and hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
			out_label_q  <= '0;
			out_status_q <= nnc_pkg::STAT_OK;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (fire) begin
						out_valid_q  <= 1'b1;
						out_label_q  <= '0;
						out_status_q <= nnc_pkg::STAT_OK;
						case (req.cmd)
							nnc_pkg::CMD_LOAD: begin
								if (has_room) begin
									count_q <= count_q + CW'(1);
								end else begin
									out_status_q <= nnc_pkg::STAT_FULL;
								end
							end
							nnc_pkg::CMD_QUERY: begin
								if (noisy) begin
									out_status_q <= nnc_pkg::STAT_NOISE;
								end else if (count_q == '0) begin
									out_status_q <= nnc_pkg::STAT_EMPTY;
								end else begin
									out_valid_q <= 1'b0;
									k_q         <= '0;
									state_q     <= S_ISSUE;
								end
							end
							nnc_pkg::CMD_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_ISSUE: begin
					k_q <= k_q + IW'(1);
					if (last_issue) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (tag_out.vld && tag_out.last) begin
						out_valid_q  <= 1'b1;
						out_label_q  <= take_best ? tag_out.label : best_label_q;
						out_status_q <= nnc_pkg::STAT_OK;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.predicted_label = out_label_q;
	assign rsp.status          = out_status_q;

endmodule
`default_nettype wire
